FILE: design/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types and codes shared by the sorted timer queue core and its cells.
// ----------------------------------------------------------------------------
package stq_pkg;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_SET  = 2'd1,
      ACT_FREE = 2'd2,
      ACT_NOP  = 2'd3
   } action_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [30:0] timeout;
      logic [15:0] timer_id;
      logic [15:0] handle;
   } req_word_type;

   typedef struct packed {
      logic        fired;
      logic [15:0] fired_id;
      logic [15:0] fired_handle;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] fire_time;
      logic [15:0] timer_id;
      logic [15:0] handle;
   } entry_type;

   typedef struct packed {
      logic        en;
      action_type  op;
      logic        pop;
      logic [31:0] fire_time;
      logic [15:0] timer_id;
      logic [15:0] handle;
   } cell_ctl_type;

endpackage

FILE: design/stq_cell.sv
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted timer row: holds one timer, compares it against the
// incoming word and shifts toward head or tail with its neighbors.
// ----------------------------------------------------------------------------
module stq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cell_ctl_type ctl,
   input  stq_pkg::entry_type    prev_entry,
   input  stq_pkg::entry_type    next_entry,
   input  logic                  prev_stop,
   input  logic                  next_stop,
   input  logic                  prev_found,
   output stq_pkg::entry_type    entry,
   output logic                  stop,
   output logic                  found
);
   import stq_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   entry_type          data_ff;
   entry_type          data_in;
   logic [31:0]        diff;
   logic               later;
   logic               match;

   assign entry = '{valid: valid_ff, fire_time: data_ff.fire_time,
                    timer_id: data_ff.timer_id, handle: data_ff.handle};

   assign diff  = data_ff.fire_time - ctl.fire_time;
   assign later = (diff != 32'd0) && !diff[31];
   assign stop  = (valid_ff && !later) || next_stop;
   assign match = valid_ff && (data_ff.handle == ctl.handle);
   assign found = prev_found || match;

   always_comb begin
      valid_in = valid_ff;
      data_in  = entry;
      if (ctl.en) begin
         unique case (ctl.op)
            ACT_TICK: begin
               if (ctl.pop) begin
                  valid_in = next_entry.valid;
                  data_in  = next_entry;
               end
            end
            ACT_SET: begin
               priority if (stop) begin
                  valid_in = valid_ff;
               end else if (prev_stop) begin
                  valid_in = 1'b1;
                  data_in  = '{valid: 1'b1, fire_time: ctl.fire_time,
                               timer_id: ctl.timer_id, handle: ctl.handle};
               end else begin
                  valid_in = prev_entry.valid;
                  data_in  = prev_entry;
               end
            end
            ACT_FREE: begin
               if (found) begin
                  valid_in = next_entry.valid;
                  data_in  = next_entry;
               end
            end
            ACT_NOP: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

FILE: design/sorted_timer_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// Tick counter with a row of timer cells kept in fire-time order.
// ----------------------------------------------------------------------------
// Usage:
//   req_word carries one command: tick, set a timer, free a timer or no-op.
//   Each accepted req word yields exactly one rsp word.
//   A tick advances the 32-bit time and fires at most the head timer.
//   A set places the timer after equal fire times, or reports full.
//   A free removes the first timer with a matching handle, or not found.
// Timing:
//   The rsp word is registered; rsp_valid rises in the cycle after req acceptance.
//   Throughput is one word per cycle while req_stall is low: every cell compares against the
//   command in parallel and shifts with its neighbor in the same cycle.
// Reset:
//   Time returns to zero and every cell is emptied at once.
// Backpressure:
//   While rsp_stall holds a pending rsp word and rsp_valid is high,
//   req_stall is raised and no new req word is taken.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core #(
   parameter int SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  stq_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output stq_pkg::rsp_word_type rsp_word
);
   import stq_pkg::*;

   logic               accept;
   logic [31:0]        now_ff;
   logic [31:0]        now_in;
   logic [31:0]        now_next;
   logic [31:0]        age;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_word_type       rsp_ff;
   rsp_word_type       rsp_in;
   cell_ctl_type       ctl;
   logic               full;
   logic               pop;
   entry_type          ent_c   [SLOTS+2];
   logic               stop_c  [SLOTS+2];
   logic               found_c [SLOTS+1];
   logic [SLOTS-1:0]   live_vec;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign now_next = now_ff + 32'd1;
   assign age      = now_next - ent_c[1].fire_time;
   assign pop      = ent_c[1].valid && !age[31];
   assign full     = ent_c[SLOTS].valid;

   assign ent_c[0]          = '0;
   assign ent_c[SLOTS+1]    = '0;
   assign stop_c[0]         = 1'b1;
   assign stop_c[SLOTS+1]   = 1'b0;
   assign found_c[0]        = 1'b0;

   always_comb begin
      ctl.en        = accept && !((req_word.action == ACT_SET) && full);
      ctl.op        = action_type'(req_word.action);
      ctl.pop       = pop;
      ctl.fire_time = now_ff + {1'b0, req_word.timeout};
      ctl.timer_id  = req_word.timer_id;
      ctl.handle    = req_word.handle;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (ent_c[i]),
         .next_entry (ent_c[i+2]),
         .prev_stop  (stop_c[i]),
         .next_stop  (stop_c[i+2]),
         .prev_found (found_c[i]),
         .entry      (ent_c[i+1]),
         .stop       (stop_c[i+1]),
         .found      (found_c[i+1])
      );
      assign live_vec[i] = ent_c[i+1].valid;
   end

   always_comb begin
      now_in = now_ff;
      rsp_in = '0;
      unique case (action_type'(req_word.action))
         ACT_TICK: begin
            now_in = now_next;
            if (pop) begin
               rsp_in.fired        = 1'b1;
               rsp_in.fired_id     = ent_c[1].timer_id;
               rsp_in.fired_handle = ent_c[1].handle;
            end
         end
         ACT_SET: begin
            rsp_in.status = full ? ST_FULL : ST_OK;
         end
         ACT_FREE: begin
            rsp_in.status = found_c[SLOTS] ? ST_OK : ST_NOT_FOUND;
         end
         ACT_NOP: begin
            rsp_in.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            now_ff <= now_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   a_live_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((live_vec & (live_vec + 1'b1)) == '0))
      else $error("live cells are not packed at the head");

   a_set_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.action == ACT_SET) && !full)
      |=> ($countones(live_vec) == $past($countones(live_vec)) + 1))
      else $error("set did not add one timer");

   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.action == ACT_TICK)) |=> (now_ff == $past(now_ff) + 32'd1))
      else $error("tick did not advance time");

   a_fire_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.action == ACT_TICK) && pop)
      |=> ($countones(live_vec) + 1 == $past($countones(live_vec))))
      else $error("fired timer was not removed");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted word produced no response");

endmodule
